// ----- rtl/core/rcp_pkg.sv -----
// shared constants for the random cell picker
`timescale 1ns / 1ps

package rcp_pkg;

    // field widths
    localparam int WORD_W  = 32;   // random word
    localparam int CFG_W   = 13;   // rows / cols registers
    localparam int COORD_W = 12;   // row / col results

    // configuration register indexes
    localparam int          REG_IDX_W = 1;
    localparam logic [0:0]  REG_ROWS  = 1'b0;
    localparam logic [0:0]  REG_COLS  = 1'b1;

    // register reset values
    localparam logic [CFG_W-1:0] ROWS_RESET = 13'd64;
    localparam logic [CFG_W-1:0] COLS_RESET = 13'd64;

    // request kinds
    localparam logic OP_FLIP  = 1'b0;
    localparam logic OP_RESET = 1'b1;

    // default remap table size
    localparam int MAX_CELLS_DEF = 4096;

    // divider steps, one quotient bit per cycle
    localparam int DIV_STEPS = WORD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

endpackage

// ----- rtl/core/random_cell_pick_without_repeat.sv -----
// top level of the random cell picker (sampling without repeat)
`timescale 1ns / 1ps

// Picks grid cells uniformly at random, never the same one twice until reset.
// s_ channel: one request per handshake; tuser selects flip or free-all, tdata
//   carries the random word. a free-all request gives no result.
// m_ channel: one result per flip: row and col in tdata, the no-free-cell flag
//   in tuser (then row and col are zero).
// cfg port: writing rows or cols re-initializes the picker like free-all.
// flow: a flip runs the word modulo remaining count on a bit-serial divider,
//   remap ram read and write-back (RD_SLOT, RD_LAST, WR_SLOT, WR_LAST), then
//   the index by cols on the same divider and the output state. flips are
//   taken one at a time, the next once the result is in the output register.
//   a flip on an exhausted grid skips the divider and goes straight to the
//   output state.
// reset, a free-all request and a cfg write start a clearing pass over every
//   entry of the remap ram with s_tready low; cfg writes are still taken and
//   restart the pass.
// a stalled receiver holds the result in the output register; the next
//   request is still accepted and runs until its own result is ready, then
//   waits for the output register to free up.
module random_cell_pick_without_repeat
    import rcp_pkg::*;
#(
    parameter int MAX_CELLS = MAX_CELLS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // request channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [WORD_W-1:0]    s_tdata,   // [31:0] random_word
    input  logic [0:0]           s_tuser,   // [0] op
    // result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [2*COORD_W-1:0] m_tdata,   // [11:0] row, [23:12] col
    output logic [0:0]           m_tuser,   // [0] no_free_cell
    // configuration
    input  logic                 cfg_wr_en,
    input  logic [REG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    localparam int IDX_W  = $clog2(MAX_CELLS);           // slot / cell index
    localparam int CNT_W  = $clog2(MAX_CELLS + 1);       // remaining count
    localparam int DV_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W; // divisor width
    localparam int PROD_W = 2 * CFG_W;
    localparam int MEM_W  = IDX_W + 1;                   // {valid, value}

    // fsm codes
    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_MOD     = 4'd2;
    localparam logic [3:0] S_RD_SLOT = 4'd3;
    localparam logic [3:0] S_RD_LAST = 4'd4;
    localparam logic [3:0] S_WR_SLOT = 4'd5;
    localparam logic [3:0] S_WR_LAST = 4'd6;
    localparam logic [3:0] S_XDIV    = 4'd7;
    localparam logic [3:0] S_OUT     = 4'd8;

    logic [3:0]         state_reg, state_next;
    logic [IDX_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [CNT_W-1:0]   remaining_reg, remaining_next;
    logic [CFG_W-1:0]   rows_reg, rows_next;
    logic [CFG_W-1:0]   cols_reg, cols_next;
    logic [WORD_W-1:0]  div_q_reg, div_q_next;
    logic [DV_W-1:0]    div_r_reg, div_r_next;
    logic [DV_W-1:0]    div_d_reg, div_d_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [IDX_W-1:0]   slot_reg, slot_next;
    logic [IDX_W-1:0]   x_reg, x_next;
    logic               err_reg, err_next;
    logic               m_valid_reg, m_valid_next;
    logic [COORD_W-1:0] m_row_reg, m_row_next;
    logic [COORD_W-1:0] m_col_reg, m_col_next;
    logic               m_err_reg, m_err_next;

    // remap ram
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [MEM_W-1:0]   ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [MEM_W-1:0]   ram_rdata;
    logic               rd_valid;
    logic [IDX_W-1:0]   rd_value;

    logic [CFG_W-1:0]   eff_rows, eff_cols;
    logic [PROD_W-1:0]  grid_prod;
    logic [CNT_W-1:0]   grid_cells;
    logic [IDX_W-1:0]   last_idx;
    logic [DV_W:0]      div_shift;
    logic [DV_W+1:0]    div_diff;
    logic               div_done;
    logic               s_fire;
    logic               out_free;
    logic               cfg_hit;

    rcp_ram #(
        .WIDTH (MEM_W),
        .DEPTH (MAX_CELLS)
    ) u_remap_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_valid = ram_rdata[IDX_W];
    assign rd_value = ram_rdata[IDX_W-1:0];

    // zero rows or cols count as one; the grid saturates at the table size
    assign eff_rows   = (rows_reg == '0) ? CFG_W'(1) : rows_reg;
    assign eff_cols   = (cols_reg == '0) ? CFG_W'(1) : cols_reg;
    assign grid_prod  = PROD_W'(eff_rows) * PROD_W'(eff_cols);
    assign grid_cells = (grid_prod > PROD_W'(MAX_CELLS)) ? CNT_W'(MAX_CELLS)
                                                          : CNT_W'(grid_prod);

    // last live slot; only used while remaining is nonzero
    assign last_idx = IDX_W'(remaining_reg - CNT_W'(1));

    // restoring divider step
    assign div_shift = {div_r_reg, div_q_reg[WORD_W-1]};
    assign div_diff  = {1'b0, div_shift} - {2'b00, div_d_reg};
    assign div_done  = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));

    assign cfg_hit  = cfg_wr_en && (cfg_addr == REG_ROWS || cfg_addr == REG_COLS);
    assign s_tready = (state_reg == S_IDLE) && !cfg_wr_en;
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // ram port selection
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = last_idx;
        ram_wdata = '0;
        // the slot comes straight from the remainder while slot_reg loads
        ram_raddr = (state_reg == S_RD_SLOT) ? div_r_reg[IDX_W-1:0] : last_idx;
        unique case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
            end
            S_WR_SLOT: begin
                // last slot's value moves into the chosen slot
                ram_we    = 1'b1;
                ram_waddr = slot_reg;
                ram_wdata = {1'b1, rd_valid ? rd_value : last_idx};
            end
            S_WR_LAST: begin
                // cleared after the slot write, so slot == last ends cleared
                ram_we    = 1'b1;
                ram_waddr = last_idx;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // control and datapath
    always_comb begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        remaining_next = remaining_reg;
        rows_next      = rows_reg;
        cols_next      = cols_reg;
        div_q_next     = div_q_reg;
        div_r_next     = div_r_reg;
        div_d_next     = div_d_reg;
        div_cnt_next   = div_cnt_reg;
        slot_next      = slot_reg;
        x_next         = x_reg;
        err_next       = err_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_row_next     = m_row_reg;
        m_col_next     = m_col_reg;
        m_err_next     = m_err_reg;

        unique case (state_reg)
            S_CLEAR: begin
                remaining_next = grid_cells;
                clr_addr_next  = clr_addr_reg + IDX_W'(1);
                if (clr_addr_reg == IDX_W'(MAX_CELLS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_fire) begin
                    if (s_tuser[0] == OP_RESET) begin
                        state_next    = S_CLEAR;
                        clr_addr_next = '0;
                    end else if (remaining_reg == '0) begin
                        err_next   = 1'b1;
                        state_next = S_OUT;
                    end else begin
                        // slot = word mod remaining
                        err_next     = 1'b0;
                        div_q_next   = s_tdata;
                        div_r_next   = '0;
                        div_d_next   = DV_W'(remaining_reg);
                        div_cnt_next = '0;
                        state_next   = S_MOD;
                    end
                end
            end
            S_MOD, S_XDIV: begin
                if (div_diff[DV_W+1]) begin
                    div_r_next = div_shift[DV_W-1:0];
                    div_q_next = {div_q_reg[WORD_W-2:0], 1'b0};
                end else begin
                    div_r_next = div_diff[DV_W-1:0];
                    div_q_next = {div_q_reg[WORD_W-2:0], 1'b1};
                end
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_done) begin
                    state_next = (state_reg == S_MOD) ? S_RD_SLOT : S_OUT;
                end
            end
            S_RD_SLOT: begin
                slot_next  = div_r_reg[IDX_W-1:0];
                state_next = S_RD_LAST;
            end
            S_RD_LAST: begin
                // slot read data arrives here
                x_next     = rd_valid ? rd_value : slot_reg;
                state_next = S_WR_SLOT;
            end
            S_WR_SLOT: begin
                state_next = S_WR_LAST;
            end
            S_WR_LAST: begin
                // row / col = index by cols
                remaining_next = remaining_reg - CNT_W'(1);
                div_q_next     = WORD_W'(x_reg);
                div_r_next     = '0;
                div_d_next     = DV_W'(eff_cols);
                div_cnt_next   = '0;
                state_next     = S_XDIV;
            end
            S_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_row_next   = err_reg ? '0 : div_q_reg[COORD_W-1:0];
                    m_col_next   = err_reg ? '0 : div_r_reg[COORD_W-1:0];
                    m_err_next   = err_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase

        // register write re-initializes the picker
        if (cfg_hit) begin
            if (cfg_addr == REG_ROWS) begin
                rows_next = cfg_wdata;
            end else begin
                cols_next = cfg_wdata;
            end
            state_next    = S_CLEAR;
            clr_addr_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            remaining_reg <= '0;
            rows_reg      <= ROWS_RESET;
            cols_reg      <= COLS_RESET;
            div_cnt_reg   <= '0;
            err_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            remaining_reg <= remaining_next;
            rows_reg      <= rows_next;
            cols_reg      <= cols_next;
            div_cnt_reg   <= div_cnt_next;
            err_reg       <= err_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        div_q_reg <= div_q_next;
        div_r_reg <= div_r_next;
        div_d_reg <= div_d_next;
        slot_reg  <= slot_next;
        x_reg     <= x_next;
        m_row_reg <= m_row_next;
        m_col_reg <= m_col_next;
        m_err_reg <= m_err_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_col_reg, m_row_reg};
    assign m_tuser  = m_err_reg;

endmodule

// ----- rtl/core/rcp_ram.sv -----
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module rcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
